### rtl/utf8_to_codepoint_decoder_defines.svh
// Assertion macros for the decoder's port checker file.
`ifndef UTF8_TO_CODEPOINT_DECODER_DEFINES_SVH
`define UTF8_TO_CODEPOINT_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define U8D_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("u8d assertion failed");

// Next-cycle implication, disabled while in reset.
`define U8D_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("u8d assertion failed");

`endif

### rtl/u8d_pkg.sv
// Shared types, constants and byte classifier for the UTF-8 decoder.
`default_nettype none

package u8d_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] REPL_RESET = 21'h00FFFD;

    // Byte classes
    localparam logic [2:0] CLS_ASCII   = 3'd0;
    localparam logic [2:0] CLS_CONT    = 3'd1;
    localparam logic [2:0] CLS_LEAD2   = 3'd2;
    localparam logic [2:0] CLS_LEAD3   = 3'd3;
    localparam logic [2:0] CLS_LEAD4   = 3'd4;
    localparam logic [2:0] CLS_INVALID = 3'd5;

    typedef logic [2:0] byte_class_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            is_error;
        logic            last;
    } result_t;

    // Results caused by one item: count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } step_t;

    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t cls;
        if (b <= 8'h7F)
            cls = CLS_ASCII;
        else if (b <= 8'hBF)
            cls = CLS_CONT;
        else if (b <= 8'hDF)
            cls = CLS_LEAD2;
        else if (b <= 8'hEF)
            cls = CLS_LEAD3;
        else if (b <= 8'hF7)
            cls = CLS_LEAD4;
        else
            cls = CLS_INVALID;
        return cls;
    endfunction

endpackage

`default_nettype wire

### rtl/u8d_decode.sv
// Sequence state and per-byte decode into up to two results.
`default_nettype none

module u8d_decode (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      step,
    input  wire logic [7:0]                data_byte,
    input  wire logic                      is_end,
    input  wire logic [u8d_pkg::CP_W-1:0]  repl,
    output u8d_pkg::step_t                 res
);

    logic [u8d_pkg::CP_W-1:0] acc_reg;
    logic [u8d_pkg::CP_W-1:0] acc_next;
    logic [1:0]               pend_reg;
    logic [1:0]               pend_next;
    logic [u8d_pkg::CP_W-1:0] acc_shift;
    logic [1:0]               pend_dec;
    u8d_pkg::byte_class_t     cls;
    u8d_pkg::result_t         err_last;
    u8d_pkg::result_t         byte_last;

    assign cls       = u8d_pkg::classify(data_byte);
    assign acc_shift = {acc_reg[u8d_pkg::CP_W-7:0], data_byte[5:0]};
    assign pend_dec  = pend_reg - 2'd1;
    assign err_last  = '{code_point: repl, is_error: 1'b1, last: 1'b1};
    assign byte_last = '{code_point: {{(u8d_pkg::CP_W-8){1'b0}}, data_byte},
                         is_error: 1'b0, last: 1'b1};

    always_comb
    begin
        acc_next  = acc_reg;
        pend_next = pend_reg;
        res.count = 2'd0;
        res.r0    = err_last;
        res.r1    = byte_last;
        if (is_end)
        begin
            pend_next = 2'd0;
            if (pend_reg != 2'd0)
                res.count = 2'd1;
        end
        else
        begin
            unique case (cls)
                u8d_pkg::CLS_ASCII:
                begin
                    pend_next = 2'd0;
                    if (pend_reg != 2'd0)
                    begin
                        res.count     = 2'd2;
                        res.r0.last   = 1'b0;
                    end
                    else
                    begin
                        res.count = 2'd1;
                        res.r0    = byte_last;
                    end
                end
                u8d_pkg::CLS_CONT:
                begin
                    res.count = 2'd1;
                    if (pend_reg != 2'd0)
                    begin
                        acc_next  = acc_shift;
                        pend_next = pend_dec;
                        if (pend_dec != 2'd0)
                            res.count = 2'd0;
                        res.r0 = '{code_point: acc_shift, is_error: 1'b0, last: 1'b1};
                    end
                end
                u8d_pkg::CLS_LEAD2:
                begin
                    pend_next = 2'd1;
                    acc_next  = {{(u8d_pkg::CP_W-5){1'b0}}, data_byte[4:0]};
                end
                u8d_pkg::CLS_LEAD3:
                begin
                    pend_next = 2'd2;
                    acc_next  = {{(u8d_pkg::CP_W-4){1'b0}}, data_byte[3:0]};
                end
                u8d_pkg::CLS_LEAD4:
                begin
                    pend_next = 2'd3;
                    acc_next  = {{(u8d_pkg::CP_W-3){1'b0}}, data_byte[2:0]};
                end
                default:
                begin
                    // invalid lead (0xF8 and up)
                    pend_next = 2'd0;
                    res.count = 2'd1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            pend_reg <= 2'd0;
        end
        else if (step)
        begin
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
        end
    end

endmodule

`default_nettype wire

### rtl/u8d_out_buf.sv
// Two-slot result register feeding the output channel.
`default_nettype none

module u8d_out_buf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire u8d_pkg::step_t   res,
    input  wire logic             out_stall,
    output logic                  can_load,
    output logic                  out_valid,
    output u8d_pkg::result_t      head
);

    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    u8d_pkg::result_t slot0_reg;
    u8d_pkg::result_t slot0_next;
    u8d_pkg::result_t slot1_reg;
    u8d_pkg::result_t slot1_next;
    logic             pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign head      = slot0_reg;
    assign pop       = out_valid && !out_stall;
    // room only when the buffer is empty or drains this cycle
    assign can_load  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && !out_stall);

    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (load)
        begin
            cnt_next   = res.count;
            slot0_next = res.r0;
            slot1_next = res.r1;
        end
        else if (pop)
        begin
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire

### rtl/utf8_to_codepoint_decoder.sv
// Top level of the UTF-8 byte stream to code point decoder.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in      | to block  | in_valid / in_stall  | data_byte, is_end
//  out     | from block| out_valid / out_stall| code_point, is_error, last
//  cfg     | to block  | cfg_we               | cfg_wdata (replacement char)
//
// An item is decoded in the cycle it is accepted; its results appear on out
// in the next cycle. One item per cycle while out keeps taking results.
// An item that yields two results (error plus ASCII byte) holds the input
// off while the second result drains.
// in_stall follows the two-slot result register and out_stall combinationally.
// Reset clears the sequence state and restores the replacement char to U+FFFD.
`default_nettype none

module utf8_to_codepoint_decoder (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // configuration
    input  wire logic                      cfg_we,
    input  wire logic [u8d_pkg::CP_W-1:0]  cfg_wdata,
    // byte input
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [7:0]                data_byte,
    input  wire logic                      is_end,
    // code point output
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [u8d_pkg::CP_W-1:0]       code_point,
    output logic                           is_error,
    output logic                           last
);

    logic [u8d_pkg::CP_W-1:0] repl_reg;
    logic                     accept;
    logic                     can_load;
    u8d_pkg::step_t           res;
    u8d_pkg::result_t         head;

    // replacement char register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            repl_reg <= u8d_pkg::REPL_RESET;
        else if (cfg_we)
            repl_reg <= cfg_wdata;
    end

    assign in_stall = !can_load;
    assign accept   = in_valid && can_load;

    u8d_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .data_byte (data_byte),
        .is_end    (is_end),
        .repl      (repl_reg),
        .res       (res)
    );

    u8d_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res       (res),
        .out_stall (out_stall),
        .can_load  (can_load),
        .out_valid (out_valid),
        .head      (head)
    );

    assign code_point = head.code_point;
    assign is_error   = head.is_error;
    assign last       = head.last;

endmodule

`default_nettype wire

### rtl/u8d_port_chk.sv
// Port-level assertion checker for the UTF-8 decoder, bound to the top level.
`default_nettype none

`include "utf8_to_codepoint_decoder_defines.svh"

module u8d_port_chk (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_stall,
    input wire logic [7:0]                data_byte,
    input wire logic                      is_end,
    input wire logic                      out_valid,
    input wire logic                      out_stall,
    input wire logic [u8d_pkg::CP_W-1:0]  code_point,
    input wire logic                      is_error,
    input wire logic                      last
);

    logic in_acc;
    logic out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // stalled result holds
    `U8D_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(code_point) && $stable(is_error) && $stable(last))

    // only the error in front of an ASCII byte is not last
    `U8D_ASSERT_NOW(a_nonlast_err, clk, rst_n, out_valid && !last, is_error)

    // the ASCII byte follows right after its error
    `U8D_ASSERT_NEXT(a_pair_follow, clk, rst_n, out_acc && !last,
        out_valid && !is_error && last)

    // end marker yields nothing or one final error
    `U8D_ASSERT_NEXT(a_end_flush, clk, rst_n, in_acc && is_end,
        !out_valid || (is_error && last))

    // an ASCII byte always yields a result
    `U8D_ASSERT_NEXT(a_ascii_out, clk, rst_n, in_acc && !is_end && !data_byte[7],
        out_valid)

endmodule

bind utf8_to_codepoint_decoder u8d_port_chk u_port_chk (.*);

`default_nettype wire
